// ----- src/cqi_pkg.sv -----
// Shared types and constants of the clamped quintic interpolator.
`default_nettype none
package cqi_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_INTERP = 2'd0,
		ST_START  = 2'd1,
		ST_END    = 2'd2,
		ST_SAT    = 2'd3
	} cqi_status_t;

	// Guard bits of the coefficient and Horner accumulator above the data width.
	localparam int ACC_GUARD = 11;

	// Number of Horner steps after the leading coefficient.
	localparam int HORNER_STEPS = 5;

	// Number of polynomial coefficients.
	localparam int NUM_COEF = 6;

endpackage
`default_nettype wire

// ----- src/cqi_if.sv -----
// Request and result channel interfaces of the clamped quintic interpolator.
`default_nettype none
interface cqi_in_if #(parameter int DW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] value_start;
	logic signed [DW-1:0] value_mid;
	logic signed [DW-1:0] value_end;
	logic signed [DW-1:0] slope_start;
	logic signed [DW-1:0] slope_mid;
	logic signed [DW-1:0] slope_end;
	logic signed [DW-1:0] sample_time;
	logic signed [DW-1:0] span_start;
	logic signed [DW-1:0] span_end;

	modport source (output valid, value_start, value_mid, value_end, slope_start,
		slope_mid, slope_end, sample_time, span_start, span_end, input ready);
	modport sink (input valid, value_start, value_mid, value_end, slope_start,
		slope_mid, slope_end, sample_time, span_start, span_end, output ready);
endinterface

interface cqi_out_if #(parameter int DW = 32);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] interp_value;
	logic [1:0]           clamp_status;

	modport source (output valid, interp_value, clamp_status, input ready);
	modport sink (input valid, interp_value, clamp_status, output ready);
endinterface
`default_nettype wire

// ----- src/cqi_div_stage.sv -----
// One restoring division step of the fraction divider, with its pipeline register.
`default_nettype none
module cqi_div_stage #(
	parameter int DW = 32,
	parameter int PB = 16,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem_i,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [PB-1:0] quo_i,
	input  wire logic [SW-1:0] side_i,
	output logic      [DW-1:0] rem_o,
	output logic      [DW-1:0] den_o,
	output logic      [PB-1:0] quo_o,
	output logic      [SW-1:0] side_o
);
	logic [DW:0] dbl;
	logic [DW:0] diff;
	logic        ge;

	// Shift the remainder up and subtract the divisor where it fits.
	always_comb begin
		dbl  = {rem_i, 1'b0};
		diff = dbl - {1'b0, den_i};
		ge   = (dbl >= {1'b0, den_i});
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[DW-1:0] : dbl[DW-1:0];
			den_o  <= den_i;
			quo_o  <= {quo_i[PB-2:0], ge};
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// ----- src/cqi_horner_stage.sv -----
// One Horner step acc * u + k, with its pipeline register.
`default_nettype none
module cqi_horner_stage #(
	parameter int AW  = 43,
	parameter int PB  = 16,
	parameter int SW  = 8,
	parameter int IDX = 0
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [AW-1:0] acc_i,
	input  wire logic        [PB-1:0] u_i,
	input  wire logic        [SW-1:0] side_i,
	output logic signed      [AW-1:0] acc_o,
	output logic             [PB-1:0] u_o,
	output logic             [SW-1:0] side_o
);
	logic signed [AW+PB:0] prod;
	logic signed [AW+PB:0] scaled;
	logic signed [AW-1:0]  k;

	// The product shifted down is the floor of acc * u over one full phase.
	always_comb begin
		k      = $signed(side_i[IDX*AW +: AW]);
		prod   = acc_i * $signed({1'b0, u_i});
		scaled = prod >>> PB;
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (en) begin
			acc_o  <= scaled[AW-1:0] + k;
			u_o    <= u_i;
			side_o <= side_i;
		end
	end
endmodule
`default_nettype wire

// ----- src/clamped_quintic_interpolator.sv -----
// Top level of the clamped quintic interpolator pipeline.
`default_nettype none
// Streaming quintic interpolator. While the result side is ready, one request
// per clock is accepted and one result per clock is delivered. The pipeline is
// a front register, the fraction divider (one quotient bit per pipeline stage),
// five Horner multiply-add stages and a saturating output register. Every stage
// holds its own valid bit, so bubbles close up when the result side stalls.
module clamped_quintic_interpolator #(
	parameter int DATA_WIDTH = 32,
	parameter int PHASE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cqi_in_if.sink   samples,
	cqi_out_if.source results
);
	import cqi_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int PB = PHASE_BITS;
	localparam int AW = DW + ACC_GUARD;
	localparam int SW = 2 + DW + NUM_COEF * AW;
	localparam int NS = PB + HORNER_STEPS + 2;
	localparam int CV_LO = NUM_COEF * AW;
	localparam int ST_LO = CV_LO + DW;
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	localparam logic signed [AW-1:0] K1  = AW'(1);
	localparam logic signed [AW-1:0] K4  = AW'(4);
	localparam logic signed [AW-1:0] K5  = AW'(5);
	localparam logic signed [AW-1:0] K6  = AW'(6);
	localparam logic signed [AW-1:0] K7  = AW'(7);
	localparam logic signed [AW-1:0] K8  = AW'(8);
	localparam logic signed [AW-1:0] K12 = AW'(12);
	localparam logic signed [AW-1:0] K13 = AW'(13);
	localparam logic signed [AW-1:0] K16 = AW'(16);
	localparam logic signed [AW-1:0] K23 = AW'(23);
	localparam logic signed [AW-1:0] K24 = AW'(24);
	localparam logic signed [AW-1:0] K32 = AW'(32);
	localparam logic signed [AW-1:0] K34 = AW'(34);
	localparam logic signed [AW-1:0] K40 = AW'(40);
	localparam logic signed [AW-1:0] K52 = AW'(52);
	localparam logic signed [AW-1:0] K66 = AW'(66);
	localparam logic signed [AW-1:0] K68 = AW'(68);

	// Stage valid bits and per-stage advance enables.
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = results.ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign samples.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= samples.valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Front stage: clamp decision, fraction operands and coefficients.
	logic                 asc, at_start, at_end;
	logic signed [DW:0]   dnum, dden;
	logic        [DW:0]   anum, aden;
	logic signed [AW-1:0] vs, vm, ve, ds, dm, de;
	logic signed [AW-1:0] cw, cz, ca, cb;
	cqi_status_t          st_c;

	always_comb begin
		asc = (samples.span_start <= samples.span_end);
		if (asc) begin
			at_start = (samples.sample_time <= samples.span_start);
			at_end   = (samples.sample_time >= samples.span_end);
		end else begin
			at_start = (samples.sample_time >= samples.span_start);
			at_end   = (samples.sample_time <= samples.span_end);
		end
		if (at_start) begin
			st_c = ST_START;
		end else if (at_end) begin
			st_c = ST_END;
		end else begin
			st_c = ST_INTERP;
		end
		dnum = (DW+1)'(samples.sample_time) - (DW+1)'(samples.span_start);
		dden = (DW+1)'(samples.span_end) - (DW+1)'(samples.span_start);
		anum = dnum[DW] ? -dnum : dnum;
		aden = dden[DW] ? -dden : dden;
		vs = AW'(samples.value_start);
		vm = AW'(samples.value_mid);
		ve = AW'(samples.value_end);
		ds = AW'(samples.slope_start);
		dm = AW'(samples.slope_mid);
		de = AW'(samples.slope_end);
		cw = K4*de + K16*dm + K4*ds - K24*ve + K24*vs;
		cz = K16*vm + K52*ve - K8*de - K40*dm - K12*ds - K68*vs;
		ca = K5*de + K32*dm + K13*ds - K34*ve - K32*vm + K66*vs;
		cb = K7*ve + K16*vm - K1*de - K8*dm - K6*ds - K23*vs;
	end

	logic [DW-1:0] rem_d  [PB+1];
	logic [DW-1:0] den_d  [PB+1];
	logic [PB-1:0] quo_d  [PB+1];
	logic [SW-1:0] side_d [PB+1];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			rem_d[0]  <= anum[DW-1:0];
			den_d[0]  <= aden[DW-1:0];
			quo_d[0]  <= '0;
			side_d[0] <= {st_c, at_start ? samples.value_start : samples.value_end,
				cw, cz, ca, cb, ds, vs};
		end
	end

	// Fraction divider, one quotient bit per stage.
	for (genvar k = 0; k < PB; k++) begin : g_div
		cqi_div_stage #(.DW(DW), .PB(PB), .SW(SW)) u_div (
			.clk    (clk),
			.en     (en[k+2]),
			.rem_i  (rem_d[k]),
			.den_i  (den_d[k]),
			.quo_i  (quo_d[k]),
			.side_i (side_d[k]),
			.rem_o  (rem_d[k+1]),
			.den_o  (den_d[k+1]),
			.quo_o  (quo_d[k+1]),
			.side_o (side_d[k+1])
		);
	end

	// Horner evaluation, starting from the leading coefficient.
	logic signed [AW-1:0] acc_h  [HORNER_STEPS+1];
	logic        [PB-1:0] u_h    [HORNER_STEPS+1];
	logic        [SW-1:0] side_h [HORNER_STEPS+1];

	assign acc_h[0]  = $signed(side_d[PB][(NUM_COEF-1)*AW +: AW]);
	assign u_h[0]    = quo_d[PB];
	assign side_h[0] = side_d[PB];

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
		cqi_horner_stage #(.AW(AW), .PB(PB), .SW(SW), .IDX(HORNER_STEPS-1-j)) u_hs (
			.clk    (clk),
			.en     (en[PB+2+j]),
			.acc_i  (acc_h[j]),
			.u_i    (u_h[j]),
			.side_i (side_h[j]),
			.acc_o  (acc_h[j+1]),
			.u_o    (u_h[j+1]),
			.side_o (side_h[j+1])
		);
	end

	// Output register: clamp selection and saturation.
	logic signed [AW-1:0] acc_f;
	logic [SW-1:0]        side_f;
	cqi_status_t          st_f;
	logic                 ovf;
	logic signed [DW-1:0] val_f;
	logic signed [DW-1:0] value_q;
	cqi_status_t          status_q;

	always_comb begin
		acc_f  = acc_h[HORNER_STEPS];
		side_f = side_h[HORNER_STEPS];
		st_f   = cqi_status_t'(side_f[ST_LO +: 2]);
		ovf    = (acc_f[AW-1:DW-1] != {(AW-DW+1){acc_f[AW-1]}});
		if (st_f != ST_INTERP) begin
			val_f = side_f[CV_LO +: DW];
		end else if (ovf) begin
			val_f = acc_f[AW-1] ? MINV : MAXV;
			st_f  = ST_SAT;
		end else begin
			val_f = acc_f[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			value_q  <= val_f;
			status_q <= st_f;
		end
	end

	assign results.valid        = vld_q[NS];
	assign results.interp_value = value_q;
	assign results.clamp_status = status_q;

`ifndef SYNTHESIS
	// A waiting result side never blocks requests while it takes results.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		results.ready |-> samples.ready)
		else $error("request side blocked while results are taken");

	// Requests are refused only when the first stage holds an item.
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> vld_q[1])
		else $error("request refused with an empty first stage");

	// A saturated result is one of the two extreme values.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.clamp_status == ST_SAT) |->
		(results.interp_value == MAXV || results.interp_value == MINV))
		else $error("saturated result is not an extreme value");

	// An accepted request enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> vld_q[1])
		else $error("accepted request lost at the first stage");
`endif
endmodule
`default_nettype wire
